/* sv/firal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firal_pkg: shared types and constants of the free range index allocator
// Item formats, range table entry layout, request and status codes.
// ----------------------------------------------------------------------------
package firal_pkg;

  // pool and table geometry
  localparam int unsigned PoolSlots = 1024;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CntW      = 11;

  // request codes carried in func
  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  // result status codes
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusEmpty = 1'b1;

  // input item
  typedef struct packed {
    logic            func;
    logic [IdxW-1:0] slot_index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [IdxW-1:0] granted_index;
    logic            status;
    logic [CntW-1:0] free_range_total;
  } out_item_t;

  // one free range [start, stop)
  typedef struct packed {
    logic [CntW-1:0] start;
    logic [CntW-1:0] stop;
  } range_t;

endpackage

/* sv/firal_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firal_ram: simple dual-port RAM for the range table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module firal_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 22
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/free_range_index_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_range_index_allocator: slot index allocator over a table of free ranges
// Hands out the lowest slot of the first free range and takes slots back by
// growing a range or inserting a one-slot range, kept in a single RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | input     | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i | out_item_o (out_item_t)
//  cfg     | input     | cfg_we_i, no wait         | cfg_data_i (pool size)
//
//  An item runs through one RAM port pair under the sequencer, one table
//  entry per cycle, with N ranges in the table. Allocate: StAlloc takes the
//  start of the first range; when that range empties and other ranges are
//  left, StShiftDown moves them down. Free: StScan checks the ranges, then
//  StPut appends, or StShiftUp moves later ranges up and StPut inserts.
//  Each item ends in StDone, and the next one is taken in StIdle.
//  After reset or a pool size write, entry 0 is rewritten in StIdle before the
//  next item is taken. A result waiting on out_ready_i holds the sequencer
//  at its last step; the next item is still taken once the sequencer is free.
//
module free_range_index_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  firal_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output firal_pkg::out_item_t                out_item_o,
  input  logic                                cfg_we_i,
  input  logic [firal_pkg::CntW-1:0]          cfg_data_i
);

  localparam int unsigned IdxW = firal_pkg::IdxW;
  localparam int unsigned CntW = firal_pkg::CntW;
  localparam logic [CntW-1:0] SlotsCnt = CntW'(firal_pkg::PoolSlots);

  typedef enum logic [2:0] {
    StIdle,
    StAlloc,
    StShiftDown,
    StScan,
    StShiftUp,
    StPut,
    StDone
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       ptr_q, ptr_d;
  logic                  pend_q, pend_d;
  logic [IdxW-1:0]       pos_q, pos_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       total_q, total_d;
  logic [CntW-1:0]       pool_q, pool_d;
  logic                  init_q, init_d;
  logic [IdxW-1:0]       gnt_q, gnt_d;
  logic                  sts_q, sts_d;
  logic                  out_valid_q, out_valid_d;
  firal_pkg::out_item_t  out_q, out_d;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  firal_pkg::range_t     ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [$bits(firal_pkg::range_t)-1:0] ram_rdata;
  firal_pkg::range_t     rd_entry;

  logic [CntW-1:0]       idx_ext;
  logic [CntW-1:0]       idx_inc;
  logic [CntW-1:0]       next_start;
  logic [CntW-1:0]       chk_addr;
  logic [CntW-1:0]       dn_waddr;
  logic [CntW-1:0]       up_waddr;
  logic [CntW-1:0]       up_raddr;
  logic [CntW-1:0]       cfg_size;

  // range table storage
  firal_ram #(
    .Depth(firal_pkg::PoolSlots),
    .Width($bits(firal_pkg::range_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry   = firal_pkg::range_t'(ram_rdata);
  assign idx_ext    = {1'b0, idx_q};
  assign idx_inc    = idx_ext + CntW'(1);
  assign next_start = rd_entry.start + CntW'(1);
  assign chk_addr   = ptr_q - CntW'(1);
  assign dn_waddr   = ptr_q - CntW'(2);
  assign up_waddr   = ptr_q + CntW'(1);
  assign up_raddr   = ptr_q - CntW'(1);

  // pool size clamp for register writes
  always_comb begin
    cfg_size = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_size = CntW'(1);
    end else if (cfg_data_i > SlotsCnt) begin
      cfg_size = SlotsCnt;
    end
  end

  assign in_ready_o = (state_q == StIdle) && !init_q;

  // sequencer
  always_comb begin
    logic hit;
    hit         = 1'b0;
    state_d     = state_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    total_d     = total_q;
    pool_d      = pool_q;
    init_d      = init_q;
    gnt_d       = gnt_q;
    sts_d       = sts_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = ptr_q[IdxW-1:0];

    case (state_q)
      StIdle: begin
        // entry 0 is read here so an allocate finds it in StAlloc
        ram_raddr = '0;
        if (init_q) begin
          ram_we    = 1'b1;
          ram_wdata = '{start: '0, stop: pool_q};
          init_d    = 1'b0;
        end else if (in_valid_i) begin
          idx_d = in_item_i.slot_index;
          gnt_d = '0;
          sts_d = firal_pkg::StatusOk;
          if (in_item_i.func == firal_pkg::FuncAlloc) begin
            if (total_q == '0) begin
              sts_d   = firal_pkg::StatusEmpty;
              state_d = StDone;
            end else begin
              state_d = StAlloc;
            end
          end else if ({1'b0, in_item_i.slot_index} >= pool_q) begin
            state_d = StDone;
          end else begin
            ptr_d   = '0;
            pend_d  = 1'b0;
            state_d = StScan;
          end
        end
      end

      // take the start of the first range
      StAlloc: begin
        gnt_d = rd_entry.start[IdxW-1:0];
        if (next_start >= rd_entry.stop) begin
          total_d = total_q - CntW'(1);
          if (total_q != CntW'(1)) begin
            ptr_d   = CntW'(1);
            pend_d  = 1'b0;
            state_d = StShiftDown;
          end else begin
            state_d = StDone;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = '{start: next_start, stop: rd_entry.stop};
          state_d   = StDone;
        end
      end

      // move entries 1..total down by one, one per cycle
      StShiftDown: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dn_waddr[IdxW-1:0];
          ram_wdata = rd_entry;
        end
        if (ptr_q <= total_q) begin
          ram_raddr = ptr_q[IdxW-1:0];
          ptr_d     = ptr_q + CntW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = StDone;
        end
      end

      // check one range per cycle while the next one is read
      StScan: begin
        if (pend_q) begin
          if (rd_entry.start == idx_inc) begin
            hit       = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = chk_addr[IdxW-1:0];
            ram_wdata = '{start: idx_ext, stop: rd_entry.stop};
            state_d   = StDone;
          end else if (rd_entry.stop == idx_ext) begin
            hit       = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = chk_addr[IdxW-1:0];
            ram_wdata = '{start: rd_entry.start, stop: idx_inc};
            state_d   = StDone;
          end else if (rd_entry.start > idx_ext) begin
            hit = 1'b1;
            if (total_q == SlotsCnt) begin
              state_d = StDone;
            end else begin
              pos_d   = chk_addr[IdxW-1:0];
              ptr_d   = total_q;
              pend_d  = 1'b0;
              state_d = StShiftUp;
            end
          end
        end
        if (!hit) begin
          if (ptr_q < total_q) begin
            ram_raddr = ptr_q[IdxW-1:0];
            ptr_d     = ptr_q + CntW'(1);
            pend_d    = 1'b1;
          end else if (total_q == SlotsCnt) begin
            state_d = StDone;
          end else begin
            // no range fits: append at the end
            pos_d   = total_q[IdxW-1:0];
            pend_d  = 1'b0;
            state_d = StPut;
          end
        end
      end

      // open a gap at pos: move entries pos..total-1 up, top first
      StShiftUp: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = up_waddr[IdxW-1:0];
          ram_wdata = rd_entry;
        end
        if (ptr_q > {1'b0, pos_q}) begin
          ram_raddr = up_raddr[IdxW-1:0];
          ptr_d     = up_raddr;
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = StPut;
        end
      end

      // write the one-slot range
      StPut: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = '{start: idx_ext, stop: idx_inc};
        total_d   = total_q + CntW'(1);
        state_d   = StDone;
      end

      // hand the result to the output register
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{granted_index: gnt_q, status: sts_q, free_range_total: total_q};
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // pool size write restarts the table
    if (cfg_we_i) begin
      pool_d  = cfg_size;
      total_d = CntW'(1);
      init_d  = 1'b1;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      total_q     <= CntW'(1);
      pool_q      <= SlotsCnt;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      total_q     <= total_d;
      pool_q      <= pool_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    idx_q <= idx_d;
    gnt_q <= gnt_d;
    sts_q <= sts_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a refused allocate only happens on an empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == firal_pkg::StatusEmpty)
      |-> (out_item_o.free_range_total == '0))
    else $error("refused allocate with free ranges left");

  // one item at a time in the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  // range count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= SlotsCnt)
    else $error("range count beyond table depth");

endmodule

/* verif/free_range_index_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_range_index_allocator_tb: self-checking bench for the slot allocator
// Drives allocate and free requests through the valid/ready channels, keeps
// its own copy of the free range table to predict every reply, and checks
// each reply field by field. Covers the pool size bounds, frees outside the
// pool and an empty pool, then random traffic under several idling patterns
// on both channels.
// ----------------------------------------------------------------------------
module free_range_index_allocator_tb;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  firal_pkg::in_item_t           in_item_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  firal_pkg::out_item_t          out_item_o;
  logic                          cfg_we_i;
  logic [firal_pkg::CntW-1:0]    cfg_data_i;

  // shadow copy of the free range table
  logic [firal_pkg::CntW-1:0]    free_lo [firal_pkg::PoolSlots];
  logic [firal_pkg::CntW-1:0]    free_hi [firal_pkg::PoolSlots];
  int unsigned                   free_count;
  logic [firal_pkg::CntW-1:0]    pool_slots;

  firal_pkg::out_item_t          replies_due [$];
  firal_pkg::out_item_t          owed;
  int                            held_slots [$];
  int                            mismatches = 0;
  int                            send_idle_pct = 0;
  int                            recv_idle_pct = 0;

  free_range_index_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // reinitialise the table to one full range, clamping the size
  function automatic void set_pool(logic [firal_pkg::CntW-1:0] raw);
    logic [firal_pkg::CntW-1:0] v;
    v = raw;
    if (v == '0) v = firal_pkg::CntW'(1);
    if (v > firal_pkg::CntW'(firal_pkg::PoolSlots)) v = firal_pkg::CntW'(firal_pkg::PoolSlots);
    pool_slots = v;
    for (int j = 0; j < firal_pkg::PoolSlots; j++) begin
      free_lo[j] = '0;
      free_hi[j] = '0;
    end
    free_hi[0] = v;
    free_count = 1;
  endfunction

  // one-slot range at pos, later ranges move up; dropped when the table is full
  function automatic void insert_range(int unsigned pos, logic [firal_pkg::CntW-1:0] idx);
    if (free_count >= firal_pkg::PoolSlots) return;
    for (int j = int'(free_count); j > int'(pos); j--) begin
      free_lo[j] = free_lo[j-1];
      free_hi[j] = free_hi[j-1];
    end
    free_lo[pos] = idx;
    free_hi[pos] = idx + 1'b1;
    free_count++;
  endfunction

  // apply one request to the shadow table and work out its reply
  function automatic firal_pkg::out_item_t step_allocator(firal_pkg::in_item_t it);
    firal_pkg::out_item_t       r;
    logic [firal_pkg::CntW-1:0] idx;
    int unsigned                pos;
    bit                         found;
    bit                         grown;
    r     = '0;
    idx   = firal_pkg::CntW'(it.slot_index);
    found = 1'b0;
    grown = 1'b0;
    pos   = free_count;
    if (it.func == firal_pkg::FuncAlloc) begin
      if (free_count == 0) begin
        r.status = firal_pkg::StatusEmpty;
      end else begin
        r.granted_index = free_lo[0][firal_pkg::IdxW-1:0];
        free_lo[0] = free_lo[0] + 1'b1;
        // first range used up: drop it
        if (free_lo[0] >= free_hi[0]) begin
          free_count--;
          for (int j = 0; j < free_count; j++) begin
            free_lo[j] = free_lo[j+1];
            free_hi[j] = free_hi[j+1];
          end
          free_lo[free_count] = '0;
          free_hi[free_count] = '0;
        end
      end
    end else if (idx < pool_slots) begin
      // first range that fits wins
      for (int i = 0; i < free_count && !found; i++) begin
        if (free_lo[i] == idx + 1'b1) begin
          free_lo[i] = idx;
          found = 1'b1;
          grown = 1'b1;
        end else if (free_hi[i] == idx) begin
          free_hi[i] = idx + 1'b1;
          found = 1'b1;
          grown = 1'b1;
        end else if (free_lo[i] > idx) begin
          pos = unsigned'(i);
          found = 1'b1;
        end
      end
      if (!grown) insert_range(pos, idx);
    end
    r.free_range_total = firal_pkg::CntW'(free_count);
    return r;
  endfunction

  // present one item, wait for acceptance, record its reply
  task automatic offer_request(input logic func, input logic [firal_pkg::IdxW-1:0] idx);
    firal_pkg::in_item_t  it;
    firal_pkg::out_item_t r;
    it.func       = func;
    it.slot_index = idx;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    r = step_allocator(it);
    replies_due.insert(replies_due.size(), r);
    if (func == firal_pkg::FuncAlloc && r.status == firal_pkg::StatusOk) begin
      held_slots.insert(held_slots.size(), int'(r.granted_index));
    end
  endtask

  // let every reply come back and the sequencer settle
  task automatic drain_replies();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool_size(input logic [firal_pkg::CntW-1:0] raw);
    drain_replies();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= raw;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    set_pool(raw);
    held_slots.delete();
  endtask

  // reply checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        $display("%t unexpected item: granted %0d status %0d ranges %0d", $time,
                 out_item_o.granted_index, out_item_o.status, out_item_o.free_range_total);
        mismatches++;
      end else begin
        owed = replies_due[0];
        replies_due.delete(0);
        if (out_item_o.granted_index !== owed.granted_index) begin
          $display("%t granted_index mismatch: expected %0d actual %0d", $time,
                   owed.granted_index, out_item_o.granted_index);
          mismatches++;
        end
        if (out_item_o.status !== owed.status) begin
          $display("%t status mismatch: expected %0d actual %0d", $time,
                   owed.status, out_item_o.status);
          mismatches++;
        end
        if (out_item_o.free_range_total !== owed.free_range_total) begin
          $display("%t free_range_total mismatch: expected %0d actual %0d", $time,
                   owed.free_range_total, out_item_o.free_range_total);
          mismatches++;
        end
      end
    end
  end

  // pool size after reset, grow down, grow up, insert and append
  task automatic test_default_pool();
    offer_request(firal_pkg::FuncAlloc, '0);
    offer_request(firal_pkg::FuncAlloc, '1);
    offer_request(firal_pkg::FuncAlloc, '0);
    offer_request(firal_pkg::FuncFree, 10'd1023);
    offer_request(firal_pkg::FuncFree, 10'd2);
    offer_request(firal_pkg::FuncFree, 10'd0);
    offer_request(firal_pkg::FuncFree, 10'd1);
    offer_request(firal_pkg::FuncAlloc, '0);
  endtask

  // size clamping, frees outside the pool, empty pool, double free
  task automatic test_pool_size_bounds();
    write_pool_size(11'd0);
    offer_request(firal_pkg::FuncAlloc, '0);
    offer_request(firal_pkg::FuncAlloc, '1);
    offer_request(firal_pkg::FuncFree, 10'd1);
    offer_request(firal_pkg::FuncFree, 10'd1023);
    offer_request(firal_pkg::FuncFree, 10'd0);
    offer_request(firal_pkg::FuncAlloc, '0);
    write_pool_size(11'd2047);
    offer_request(firal_pkg::FuncFree, 10'd1023);
    offer_request(firal_pkg::FuncAlloc, '0);
    write_pool_size(11'd1025);
    offer_request(firal_pkg::FuncFree, 10'd1023);
    write_pool_size(11'd1024);
    offer_request(firal_pkg::FuncAlloc, '0);
    write_pool_size(11'd2);
    offer_request(firal_pkg::FuncAlloc, '0);
    offer_request(firal_pkg::FuncAlloc, '0);
    offer_request(firal_pkg::FuncAlloc, '0);
    offer_request(firal_pkg::FuncFree, 10'd1);
    offer_request(firal_pkg::FuncFree, 10'd0);
    offer_request(firal_pkg::FuncAlloc, '0);
  endtask

  // rounds of mostly well-formed alloc/free traffic over random pool sizes
  task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
    int                         sent;
    int                         round_len;
    int                         pick;
    int                         pos;
    logic [firal_pkg::CntW-1:0] raw;
    logic [firal_pkg::IdxW-1:0] idx;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        raw = 11'd1024;
        round_len = 40;
      end else if (pick == 1) begin
        raw = firal_pkg::CntW'($urandom_range(1025, 2047));
        round_len = 40;
      end else if (pick == 2) begin
        raw = firal_pkg::CntW'($urandom_range(0, 8));
        round_len = 20;
      end else begin
        raw = firal_pkg::CntW'($urandom_range(2, 64));
        round_len = 30;
      end
      write_pool_size(raw);
      for (int k = 0; k < round_len && sent < n_items; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50 || (pick < 88 && held_slots.size() == 0)) begin
          offer_request(firal_pkg::FuncAlloc, firal_pkg::IdxW'($urandom_range(0, 1023)));
        end else if (pick < 88) begin
          // give back a slot that is really held
          pos = $urandom_range(0, held_slots.size() - 1);
          idx = firal_pkg::IdxW'(held_slots[pos]);
          held_slots.delete(pos);
          offer_request(firal_pkg::FuncFree, idx);
        end else if (pick < 94) begin
          // likely double free inside the pool
          offer_request(firal_pkg::FuncFree,
                        firal_pkg::IdxW'($urandom_range(0, pool_slots - 1)));
        end else begin
          offer_request(firal_pkg::FuncFree, firal_pkg::IdxW'($urandom_range(0, 1023)));
        end
        sent++;
      end
    end
  endtask

  // test sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    set_pool(firal_pkg::CntW'(firal_pkg::PoolSlots));
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(posedge clk_i);

    test_default_pool();
    test_pool_size_bounds();
    test_random_traffic(190, 24, 65);
    test_random_traffic(190, 65, 24);
    test_random_traffic(170, 0, 0);

    drain_replies();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
sv/firal_pkg.sv
sv/firal_ram.sv
sv/free_range_index_allocator.sv
verif/free_range_index_allocator_tb.sv
